/* design/tpad_pkg.sv */
// Shared types, constants and helpers for the phase-angle dimmer.
package tpad_pkg;

   // Width of the delay and pulse tick counter
   localparam int unsigned COUNT_WIDTH = 16;

   localparam int unsigned DELAY_WIDTH  = 16;
   localparam int unsigned GATE_TIME_WIDTH = 16;
   localparam int unsigned FILTER_WIDTH = 8;
   localparam int unsigned CSR_WIDTH    = 16;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [FILTER_WIDTH-1:0] FILTER_MAX = {FILTER_WIDTH{1'b1}};

   // Register reset values
   localparam logic [DELAY_WIDTH-1:0]     FIRE_DELAY_RST   = 16'd0;
   localparam logic [GATE_TIME_WIDTH-1:0] GATE_PULSE_RST   = 16'd100;
   localparam logic [FILTER_WIDTH-1:0]    GLITCH_FILTER_RST = 8'd50;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FIRE_DELAY    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GATE_PULSE    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GLITCH_FILTER = 2'd2;

   typedef enum logic [1:0] {
      PH_ARMED   = 2'd0,
      PH_QUAL    = 2'd1,
      PH_DELAY   = 2'd2,
      PH_PULSE   = 2'd3
   } phase_type;

   // Limit for a tick count: zero acts as one, large values saturate
   function automatic logic [COUNT_WIDTH-1:0] clamp_limit(input logic [15:0] value);
      logic [31:0] v32;
      logic [31:0] max32;
      v32   = 32'(value);
      max32 = 32'(CNT_MAX);
      if (v32 == 32'd0) begin
         v32 = 32'd1;
      end
      if (v32 > max32) begin
         v32 = max32;
      end
      return COUNT_WIDTH'(v32);
   endfunction

endpackage

/* design/tpad_if.sv */
// Request and response channel interfaces of the dimmer.
interface tpad_req_if;
   logic valid;
   logic ready;
   logic zero_cross_level;

   modport source (output valid, output zero_cross_level, input ready);
   modport sink   (input valid, input zero_cross_level, output ready);
endinterface

interface tpad_rsp_if;
   import tpad_pkg::*;
   logic      valid;
   logic      ready;
   logic      gate_drive;
   logic      crossing_seen;
   logic [1:0] phase;

   modport source (output valid, output gate_drive, output crossing_seen, output phase,
                   input ready);
   modport sink   (input valid, input gate_drive, input crossing_seen, input phase,
                   output ready);
endinterface

/* design/triac_phase_angle_dimmer.sv */
// Top level of the phase-angle TRIAC dimmer.
//
//   channel   direction  contents
//   req_if    in         zero_cross_level, one timer tick per request
//   rsp_if    out        gate_drive, crossing_seen, phase
//   csr_*     in         fire_delay_ticks, gate_pulse_ticks, glitch_filter_ticks
//
// One request per cycle; the state update and the response are computed in
// one pass and land in the state and response registers on the accepting edge.
// The response register stalls the request side only while it holds a response
// that is not being taken in the same cycle.
// Reset is synchronous: it clears the state and response valid, presets the CSRs.
module triac_phase_angle_dimmer
   import tpad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   tpad_req_if.sink                 req_if,
   tpad_rsp_if.source               rsp_if,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wr_data
);

   logic [DELAY_WIDTH-1:0]     fire_delay_ff;
   logic [GATE_TIME_WIDTH-1:0] gate_pulse_ff;
   logic [FILTER_WIDTH-1:0]    glitch_filter_ff;

   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  tick_ff, tick_in;
   logic                    ref_level_ff, ref_level_in;
   logic [FILTER_WIDTH-1:0] filter_ff, filter_in;

   logic                    rsp_valid_ff;
   logic                    gate_ff;
   logic                    seen_ff, seen_in;
   logic [1:0]              phase_out_ff;

   logic                    req_accept;
   logic                    check;
   logic [COUNT_WIDTH-1:0]  tick_inc;
   logic [COUNT_WIDTH-1:0]  delay_limit;
   logic [COUNT_WIDTH-1:0]  pulse_limit;
   logic                    level;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign level        = req_if.zero_cross_level;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fire_delay_ff    <= FIRE_DELAY_RST;
         gate_pulse_ff    <= GATE_PULSE_RST;
         glitch_filter_ff <= GLITCH_FILTER_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRE_DELAY:    fire_delay_ff    <= csr_wr_data[DELAY_WIDTH-1:0];
            CSR_GATE_PULSE:    gate_pulse_ff    <= csr_wr_data[GATE_TIME_WIDTH-1:0];
            CSR_GLITCH_FILTER: glitch_filter_ff <= csr_wr_data[FILTER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign delay_limit = clamp_limit(fire_delay_ff);
   assign pulse_limit = clamp_limit(gate_pulse_ff);
   assign tick_inc    = (tick_ff == CNT_MAX) ? tick_ff : tick_ff + COUNT_WIDTH'(1);

   // Next state for one tick
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      ref_level_in = ref_level_ff;
      filter_in    = filter_ff;
      seen_in      = 1'b0;
      check        = 1'b0;
      case (phase_ff)
         PH_ARMED: begin
            if (level != ref_level_ff) begin
               ref_level_in = level;
               filter_in    = '0;
               phase_in     = PH_QUAL;
               check        = 1'b1;
            end
         end
         PH_QUAL: begin
            if (level != ref_level_ff) begin
               ref_level_in = level;
               filter_in    = '0;
            end else if (filter_ff != FILTER_MAX) begin
               filter_in = filter_ff + FILTER_WIDTH'(1);
            end
            check = 1'b1;
         end
         PH_DELAY: begin
            tick_in = tick_inc;
            if (tick_inc >= delay_limit) begin
               tick_in  = '0;
               phase_in = PH_PULSE;
            end
         end
         default: begin
            tick_in = tick_inc;
            if (tick_inc >= pulse_limit) begin
               tick_in      = '0;
               phase_in     = PH_ARMED;
               ref_level_in = level;
            end
         end
      endcase
      // Qualified zero crossing starts the firing delay
      if (check && (filter_in >= glitch_filter_ff)) begin
         seen_in   = 1'b1;
         filter_in = '0;
         tick_in   = '0;
         phase_in  = PH_DELAY;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ARMED;
         tick_ff      <= '0;
         ref_level_ff <= 1'b0;
         filter_ff    <= '0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         ref_level_ff <= ref_level_in;
         filter_ff    <= filter_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         gate_ff      <= (phase_in == PH_PULSE);
         seen_ff      <= seen_in;
         phase_out_ff <= 2'(phase_in);
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.gate_drive    = gate_ff;
   assign rsp_if.crossing_seen = seen_ff;
   assign rsp_if.phase         = phase_out_ff;

   // Checks
   a_gate_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (gate_ff == (phase_out_ff == 2'(PH_PULSE))))
      else $error("gate drive disagrees with reported phase");

   a_seen_starts_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && seen_ff) |-> (phase_out_ff == 2'(PH_DELAY)))
      else $error("crossing reported without entering delay");

   a_tick_idle_zero: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_ARMED) || (phase_ff == PH_QUAL)) |-> (tick_ff == '0))
      else $error("tick counter not cleared while armed or qualifying");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> ($stable(seen_ff) && $stable(phase_out_ff)))
      else $error("held response overwritten");

endmodule
